FILE: design/mecanum_wheel_pwm_mixer_defines.svh
// assertion macros for the mecanum wheel pwm mixer
// expects clk and rst_n in the scope of each use
`ifndef MECANUM_WHEEL_PWM_MIXER_DEFINES_SVH
`define MECANUM_WHEEL_PWM_MIXER_DEFINES_SVH

// same-cycle implication
`define MWPM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MWPM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/mwpm_pkg.sv
// shared types, constants, elaboration-time table functions and the angle fold function of the mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mwpm_pkg;

  localparam int TRIG_FRAC_BITS_DEF = 15;
  localparam int FULL_SCALE_DEF     = 100;
  localparam int NUM_WHEELS         = 4;
  localparam int NUM_STAGES         = 7;
  localparam int LANE_STAGES        = 4;
  localparam int RECIP_SHIFT        = 28;
  localparam int CFG_IDX_W          = 1;

  localparam logic [7:0] DUTY_FLOOR_RST = 8'd50;
  localparam logic [3:0] WHEEL_POL_RST  = 4'd9;

  localparam longint PI_Q30 = 64'sd3373259426;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_WHEEL_POL  = 1'b1;

  typedef struct packed {
    logic       neg;
    logic [6:0] idx;
  } fold_t;

  typedef struct packed {
    logic [LANE_STAGES-1:0] en;
    logic [LANE_STAGES-1:0] vld;
  } lane_ctl_t;

  // sin of d degrees, d in 0..90, rounded to frac fractional bits
  function automatic longint quarter_sine(input int d, input int frac);
    longint x;
    longint x2;
    longint term;
    longint sum;
    x    = (longint'(d) * PI_Q30 + 64'sd90) / 180;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 210;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 272;
    sum  = sum + term;
    return (sum + (64'sd1 <<< (29 - frac))) >>> (30 - frac);
  endfunction

  // floor(spd / sqrt 2)
  function automatic logic [6:0] speed_scale(input int spd);
    int v;
    v = 0;
    for (int k = 0; k < 128; k++) begin
      if (2 * (v + 1) * (v + 1) <= spd * spd) begin
        v = v + 1;
      end
    end
    return 7'(v);
  endfunction

  // fold an angle in 0..359 onto the first quadrant
  function automatic fold_t fold_angle(input logic [8:0] deg);
    fold_t f;
    if (deg <= 9'd90) begin
      f.neg = 1'b0;
      f.idx = deg[6:0];
    end else if (deg <= 9'd180) begin
      f.neg = 1'b0;
      f.idx = 7'(9'd180 - deg);
    end else if (deg <= 9'd270) begin
      f.neg = 1'b1;
      f.idx = 7'(deg - 9'd180);
    end else begin
      f.neg = 1'b1;
      f.idx = 7'(9'd360 - deg);
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: design/mwpm_wheel.sv
// one wheel lane: rotation mix, truncate, saturate, duty scaling, direction
// depends on mwpm_pkg and mecanum_wheel_pwm_mixer_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_pwm_mixer_defines.svh"

module mwpm_wheel import mwpm_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int FULL_SCALE     = FULL_SCALE_DEF,
  localparam int NW            = TRIG_FRAC_BITS + 11
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire lane_ctl_t            ctl,
  input  wire logic signed [NW-1:0] base,
  input  wire logic signed [NW-1:0] rot_term,
  input  wire logic [7:0]           duty_floor,
  input  wire logic                 polarity,
  output logic [7:0]                duty,
  output logic                      dir
);

  localparam int SHW = NW - (TRIG_FRAC_BITS + 1);
  localparam int MW  = $clog2(FULL_SCALE + 1);
  localparam int PW  = MW + 8;
  localparam int RW  = RECIP_SHIFT + 1;
  localparam int XW  = PW + RW;
  localparam logic [SHW-1:0] FS_SH = SHW'(FULL_SCALE);
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << RECIP_SHIFT) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE));

  logic signed [NW-1:0] num;
  logic [NW-1:0]        abs_num;
  logic [SHW-1:0]       sh;
  logic [MW-1:0]        mag_nxt, mag_r;
  logic                 neg_nxt, neg_r;
  logic [PW-1:0]        p_nxt, p_r;
  logic                 neg_b_r, nz_b_r;
  logic [XW-1:0]        prod;
  logic [7:0]           q_nxt, q_r;
  logic                 neg_c_r, nz_c_r;
  logic [7:0]           duty_nxt, duty_r;
  logic                 dir_nxt, dir_r;

  // truncate toward zero, then saturate
  always_comb begin
    num     = base + rot_term;
    abs_num = num[NW-1] ? NW'(-num) : NW'(num);
    sh      = abs_num[NW-1:TRIG_FRAC_BITS+1];
    neg_nxt = num[NW-1] && (sh != '0);
    mag_nxt = (sh > FS_SH) ? MW'(FULL_SCALE) : sh[MW-1:0];
  end

  always_comb begin
    p_nxt = PW'(mag_r) * PW'(8'd255 - duty_floor);
  end

  // divide by full scale through the reciprocal
  always_comb begin
    prod  = XW'(p_r) * XW'(RECIP);
    q_nxt = prod[RECIP_SHIFT+7:RECIP_SHIFT];
  end

  always_comb begin
    duty_nxt = nz_c_r ? (duty_floor + q_r) : 8'd0;
    dir_nxt  = polarity ^ neg_c_r;
  end

  always_ff @(posedge clk) begin
    if (ctl.en[0]) begin
      mag_r <= mag_nxt;
      neg_r <= neg_nxt;
    end
    if (ctl.en[1]) begin
      p_r     <= p_nxt;
      neg_b_r <= neg_r;
      nz_b_r  <= (mag_r != '0);
    end
    if (ctl.en[2]) begin
      q_r     <= q_nxt;
      neg_c_r <= neg_b_r;
      nz_c_r  <= nz_b_r;
    end
    if (ctl.en[3]) begin
      duty_r <= duty_nxt;
      dir_r  <= dir_nxt;
    end
  end

  assign duty = duty_r;
  assign dir  = dir_r;

  `MWPM_ASSERT_IMPL(a_mag_saturated, ctl.vld[0], mag_r <= MW'(FULL_SCALE), "magnitude above full scale")
  `MWPM_ASSERT_IMPL(a_neg_nonzero, ctl.vld[0] && neg_r, mag_r != '0, "negative flag on zero value")
  `MWPM_ASSERT_IMPL(a_zero_quotient, ctl.vld[2] && !nz_c_r, q_r == 8'd0, "quotient nonzero for zero value")

endmodule

`default_nettype wire

FILE: design/mecanum_wheel_pwm_mixer.sv
// top level of the mecanum wheel pwm mixer: input stages, config registers, lanes
// depends on mwpm_pkg, mwpm_wheel and mecanum_wheel_pwm_mixer_defines.svh
//
// Seven-stage pipeline that takes one motion command per clock unless stalled by
// out_ready and returns four wheel duties and direction levels from its last stage;
// throughput is one command per cycle under that condition, and each stage holds its
// item only while the next one is held, so the output register may wait on out_ready
// while new commands fill empty stages. Stage one folds the heading into a
// quadrant and scales the speed by a 128-entry table, stage two reads a 91-entry
// sine table and forms the sum and difference, stage three does the speed multiply,
// and each wheel lane then mixes in rotation and saturates, multiplies by the duty
// span, divides by full scale with a reciprocal multiply and adds the floor.
// Configuration writes are taken every cycle and are meant for an idle pipeline.
`timescale 1ns / 1ps
`default_nettype none
`include "mecanum_wheel_pwm_mixer_defines.svh"

module mecanum_wheel_pwm_mixer import mwpm_pkg::*; #(
  parameter int TRIG_FRAC_BITS = TRIG_FRAC_BITS_DEF,
  parameter int FULL_SCALE     = FULL_SCALE_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [8:0]           in_heading_deg,
  input  wire logic [6:0]           in_speed_pct,
  input  wire logic signed [7:0]    in_turn_rate,
  input  wire logic                 in_drift_mode,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [7:0]                out_duty_0,
  output logic [7:0]                out_duty_1,
  output logic [7:0]                out_duty_2,
  output logic [7:0]                out_duty_3,
  output logic                      out_dir_0,
  output logic                      out_dir_1,
  output logic                      out_dir_2,
  output logic                      out_dir_3,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_data
);

  localparam int SW = TRIG_FRAC_BITS + 2;
  localparam int NW = TRIG_FRAC_BITS + 11;

  // constant tables
  logic signed [SW-1:0] sin_tab [91];
  logic [6:0]           v_tab [128];

  for (genvar g = 0; g < 91; g++) begin : g_sin
    assign sin_tab[g] = SW'(quarter_sine(g, TRIG_FRAC_BITS));
  end
  for (genvar g = 0; g < 128; g++) begin : g_spd
    assign v_tab[g] = speed_scale(g);
  end

  // config registers
  logic [7:0] duty_floor_r, duty_floor_nxt;
  logic [3:0] wheel_pol_r, wheel_pol_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    duty_floor_nxt = duty_floor_r;
    wheel_pol_nxt  = wheel_pol_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DUTY_FLOOR: duty_floor_nxt = cfg_data;
        REG_WHEEL_POL:  wheel_pol_nxt  = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_floor_r <= DUTY_FLOOR_RST;
      wheel_pol_r  <= WHEEL_POL_RST;
    end else begin
      duty_floor_r <= duty_floor_nxt;
      wheel_pol_r  <= wheel_pol_nxt;
    end
  end

  // pipeline flow control
  logic [NUM_STAGES-1:0] vld_r, vld_nxt, en;

  always_comb begin
    en[NUM_STAGES-1] = !vld_r[NUM_STAGES-1] || out_ready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
    vld_nxt[0] = en[0] ? in_valid : vld_r[0];
    for (int k = 1; k < NUM_STAGES; k++) begin
      vld_nxt[k] = en[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NUM_STAGES-1];

  // stage 1: angle fold and speed scale
  logic [8:0]        hmod;
  logic [9:0]        ang_s, ang_c;
  logic [8:0]        ang_s_m, ang_c_m;
  fold_t             s_f_nxt, c_f_nxt, s_f_r, c_f_r;
  logic [6:0]        v0_r;
  logic signed [7:0] rot0_r;
  logic              drift0_r;

  always_comb begin
    hmod    = (in_heading_deg >= 9'd360) ? (in_heading_deg - 9'd360) : in_heading_deg;
    ang_s   = {1'b0, hmod} + 10'd90;
    ang_c   = {1'b0, hmod} + 10'd180;
    ang_s_m = (ang_s >= 10'd360) ? 9'(ang_s - 10'd360) : ang_s[8:0];
    ang_c_m = (ang_c >= 10'd360) ? 9'(ang_c - 10'd360) : ang_c[8:0];
    s_f_nxt = fold_angle(ang_s_m);
    c_f_nxt = fold_angle(ang_c_m);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s_f_r    <= s_f_nxt;
      c_f_r    <= c_f_nxt;
      v0_r     <= v_tab[in_speed_pct];
      rot0_r   <= in_turn_rate;
      drift0_r <= in_drift_mode;
    end
  end

  // stage 2: table read, sum and difference
  logic signed [SW-1:0] s_val, c_val;
  logic signed [SW:0]   sd_nxt, ss_nxt, sd_r, ss_r;
  logic [6:0]           v1_r;
  logic signed [7:0]    rot1_r;
  logic                 drift1_r;

  always_comb begin
    s_val  = s_f_r.neg ? -sin_tab[s_f_r.idx] : sin_tab[s_f_r.idx];
    c_val  = c_f_r.neg ? -sin_tab[c_f_r.idx] : sin_tab[c_f_r.idx];
    sd_nxt = (SW+1)'(s_val) - (SW+1)'(c_val);
    ss_nxt = (SW+1)'(s_val) + (SW+1)'(c_val);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sd_r     <= sd_nxt;
      ss_r     <= ss_nxt;
      v1_r     <= v0_r;
      rot1_r   <= rot0_r;
      drift1_r <= drift0_r;
    end
  end

  // stage 3: speed multiply, doubled when there is no rotation
  logic signed [NW-1:0] pa, pb, ta_nxt, tb_nxt, ta_r, tb_r;
  logic signed [NW-1:0] v_ext;
  logic signed [7:0]    rot2_r;
  logic                 drift2_r;

  always_comb begin
    v_ext  = NW'($signed({1'b0, v1_r}));
    pa     = v_ext * NW'(sd_r);
    pb     = v_ext * NW'(ss_r);
    ta_nxt = (rot1_r == 8'sd0) ? (pa <<< 1) : pa;
    tb_nxt = (rot1_r == 8'sd0) ? (pb <<< 1) : pb;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ta_r     <= ta_nxt;
      tb_r     <= tb_nxt;
      rot2_r   <= rot1_r;
      drift2_r <= drift1_r;
    end
  end

  // rotation terms per wheel
  logic signed [NW-1:0] rot_h, rot_f;
  logic signed [NW-1:0] rot_add [NUM_WHEELS];

  always_comb begin
    rot_h = NW'(rot2_r) <<< TRIG_FRAC_BITS;
    rot_f = rot_h <<< 1;
    if (drift2_r) begin
      rot_add[0] = '0;
      rot_add[1] = '0;
      rot_add[2] = -rot_f;
      rot_add[3] = rot_f;
    end else begin
      rot_add[0] = rot_h;
      rot_add[1] = -rot_h;
      rot_add[2] = -rot_h;
      rot_add[3] = rot_h;
    end
  end

  // wheel lanes
  lane_ctl_t  lane_ctl;
  logic [7:0] duty_w [NUM_WHEELS];
  logic       dir_w [NUM_WHEELS];

  assign lane_ctl.en  = en[NUM_STAGES-1:NUM_STAGES-LANE_STAGES];
  assign lane_ctl.vld = vld_r[NUM_STAGES-1:NUM_STAGES-LANE_STAGES];

  for (genvar g = 0; g < NUM_WHEELS; g++) begin : g_wheel
    mwpm_wheel #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS),
      .FULL_SCALE     (FULL_SCALE)
    ) u_wheel (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (lane_ctl),
      .base       ((g % 2 == 0) ? ta_r : tb_r),
      .rot_term   (rot_add[g]),
      .duty_floor (duty_floor_r),
      .polarity   (wheel_pol_r[g]),
      .duty       (duty_w[g]),
      .dir        (dir_w[g])
    );
  end

  assign out_duty_0 = duty_w[0];
  assign out_duty_1 = duty_w[1];
  assign out_duty_2 = duty_w[2];
  assign out_duty_3 = duty_w[3];
  assign out_dir_0  = dir_w[0];
  assign out_dir_1  = dir_w[1];
  assign out_dir_2  = dir_w[2];
  assign out_dir_3  = dir_w[3];

  `MWPM_ASSERT_IMPL(a_full_when_stalled, !in_ready, &vld_r, "input stalled with a free stage")
  `MWPM_ASSERT_NEXT(a_accept_lands, in_valid && in_ready, vld_r[0], "accepted request not in first stage")
  `MWPM_ASSERT_IMPL(a_fold_range, vld_r[0], (s_f_r.idx <= 7'd90) && (c_f_r.idx <= 7'd90), "folded angle out of quadrant")

endmodule

`default_nettype wire
